/* rtl/cpss_pkg.sv */
// Shared types, constants and helpers of the periodic cubic stencil search.
// Used by the angle table memory, the search sequencer and the top level.
// Depends on nothing else.
package cpss_pkg;

    // Table geometry and field widths.
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = IDX_W + 1;
    localparam int ANGLE_W     = 16;
    localparam int QUERY_W     = 32;
    localparam int STEN_W      = ANGLE_W + 2;
    localparam int LEN_MIN     = 4;

    // One full turn in binary angle units, at the width of a stencil angle.
    localparam logic signed [STEN_W-1:0] TURN = STEN_W'(1) <<< ANGLE_W;

    // Kind of an input item, carried on tuser.
    typedef enum logic {
        ACTION_WRITE = 1'b0,
        ACTION_QUERY = 1'b1
    } action_t;

    // Search sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_LAST,
        ST_RD_ZERO,
        ST_RD_ONE,
        ST_RD_PEN,
        ST_DECIDE,
        ST_SCAN,
        ST_TAIL,
        ST_EMIT
    } seq_state_t;

    // How the last fetched angle completes the stencil.
    typedef enum logic [1:0] {
        MODE_LOW,
        MODE_HIGH,
        MODE_SCAN
    } tail_mode_t;

    // Access to the angle table.
    typedef struct packed {
        logic                      we;
        logic [IDX_W-1:0]          waddr;
        logic signed [ANGLE_W-1:0] wdata;
        logic [IDX_W-1:0]          raddr;
    } ram_req_t;

    // One stencil result.
    typedef struct packed {
        logic signed [ANGLE_W-1:0] wrapped_query;
        logic [IDX_W-1:0]          index_a;
        logic [IDX_W-1:0]          index_b;
        logic [IDX_W-1:0]          index_c;
        logic [IDX_W-1:0]          index_d;
        logic signed [STEN_W-1:0]  angle_a;
        logic signed [STEN_W-1:0]  angle_b;
        logic signed [STEN_W-1:0]  angle_c;
        logic signed [STEN_W-1:0]  angle_d;
    } stencil_result_t;

    // Sign-extend a table angle to stencil width.
    function automatic logic signed [STEN_W-1:0] widen(input logic signed [ANGLE_W-1:0] a);
        return $signed({{(STEN_W-ANGLE_W){a[ANGLE_W-1]}}, a});
    endfunction

    // Table angle moved one turn up, for a neighbor past the upper seam.
    function automatic logic signed [STEN_W-1:0] plus_turn(
        input logic signed [ANGLE_W-1:0] a);
        return widen(a) + TURN;
    endfunction

    // Table angle moved one turn down, for a neighbor past the lower seam.
    function automatic logic signed [STEN_W-1:0] minus_turn(
        input logic signed [ANGLE_W-1:0] a);
        return widen(a) - TURN;
    endfunction

endpackage

/* rtl/periodic_cubic_stencil_search.sv */
// Periodic cubic stencil search: top level with the stream ports, the length
// register, the angle table and the output register.
// Depends on cpss_pkg, cpss_angle_ram and cpss_stencil_seq.

// A write item (tuser 0) stores one angle. A query item (tuser 1) reads t[n-1],
// t[0], t[1] and t[n-2] from the single-read-port angle table, one entry a
// cycle. A query at or below t[0] or above t[n-1] then goes to the result; one
// in the first or last interval reads one more entry; any other query scans
// the table upward from index 2 one read a cycle, up to the first entry at or
// above the query. Entries must be written before they are used. The user
// must write the table length register only while the block is idle; the
// block itself does not enforce this. Values below 4 act as 4 and values
// above 1024 act as 1024. The result sits in an output register, so the next
// item is taken while a result waits.
module periodic_cubic_stencil_search (
    input  logic         aclk,
    input  logic         aresetn,
    // Table length register write.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [10:0]  cfg_data,
    // Input items.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,  // entry_index[9:0], entry_angle[25:10], query_angle[57:26]
    input  logic         s_tuser,  // action[0]
    // Result items.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata   // wrapped_query[15:0], stencil_index_a[25:16],
                                   // stencil_index_b[35:26], stencil_index_c[45:36],
                                   // stencil_index_d[55:46], stencil_angle_a[73:56],
                                   // stencil_angle_b[91:74], stencil_angle_c[109:92],
                                   // stencil_angle_d[127:110]
);
    import cpss_pkg::*;

    logic [LEN_W-1:0]          table_length_reg;
    logic                      m_tvalid_reg;
    stencil_result_t           out_reg;
    ram_req_t                  ram_req;
    logic signed [ANGLE_W-1:0] ram_rdata;
    logic                      res_valid;
    logic                      res_ready;
    stencil_result_t           res;

    // Length register; always ready to take a write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_length_reg <= LEN_W'(LEN_MIN);
        end else if (cfg_valid) begin
            table_length_reg <= cfg_data;
        end
    end

    // Angle table.
    cpss_angle_ram u_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (ram_rdata)
    );

    // Search sequencer.
    cpss_stencil_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .table_length (table_length_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_action    (action_t'(s_tuser)),
        .in_index     (s_tdata[9:0]),
        .in_angle     (s_tdata[25:10]),
        .in_query     (s_tdata[57:26]),
        .ram_req      (ram_req),
        .ram_rdata    (ram_rdata),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    // Output register: refilled when empty or when its item leaves.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    // Result packing, first field in the lowest bits.
    assign m_tdata = {out_reg.angle_d, out_reg.angle_c, out_reg.angle_b, out_reg.angle_a,
                      out_reg.index_d, out_reg.index_c, out_reg.index_b, out_reg.index_a,
                      out_reg.wrapped_query};

endmodule

/* rtl/cpss_angle_ram.sv */
// Angle table: single-port-write, single-port-read synchronous memory.
// Read data is registered: it appears in the cycle after the address.
// Depends on cpss_pkg.
module cpss_angle_ram (
    input  logic                               aclk,
    input  cpss_pkg::ram_req_t                 req,
    output logic signed [cpss_pkg::ANGLE_W-1:0] rd_data
);
    import cpss_pkg::*;

    logic signed [ANGLE_W-1:0] mem [TABLE_DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data <= mem[req.raddr];
    end

endmodule

/* rtl/cpss_stencil_seq.sv */
// Search sequencer: takes write and query items, drives the angle table and
// builds one stencil result per query. Depends on cpss_pkg; the table memory
// sits beside it at the top level.
module cpss_stencil_seq (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [cpss_pkg::LEN_W-1:0]          table_length,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  cpss_pkg::action_t                   in_action,
    input  logic [cpss_pkg::IDX_W-1:0]          in_index,
    input  logic signed [cpss_pkg::ANGLE_W-1:0] in_angle,
    input  logic signed [cpss_pkg::QUERY_W-1:0] in_query,
    output cpss_pkg::ram_req_t                  ram_req,
    input  logic signed [cpss_pkg::ANGLE_W-1:0] ram_rdata,
    output logic                                res_valid,
    input  logic                                res_ready,
    output cpss_pkg::stencil_result_t           res
);
    import cpss_pkg::*;

    seq_state_t state_reg, state_next;

    logic signed [ANGLE_W-1:0] q_reg, q_next;
    logic signed [ANGLE_W-1:0] tl_reg, tl_next;
    logic signed [ANGLE_W-1:0] t0_reg, t0_next;
    logic signed [ANGLE_W-1:0] t1_reg, t1_next;
    logic signed [ANGLE_W-1:0] tp_reg, tp_next;
    logic signed [ANGLE_W-1:0] wa_reg, wa_next;
    logic signed [ANGLE_W-1:0] wb_reg, wb_next;
    logic signed [ANGLE_W-1:0] wc_reg, wc_next;
    logic [IDX_W-1:0]          k_reg, k_next;
    tail_mode_t                mode_reg, mode_next;
    stencil_result_t           res_reg, res_next;

    logic [LEN_W-1:0] n_eff;
    logic [IDX_W-1:0] idx_last, idx_pen, idx_third;
    logic             accept;
    logic             above, below, low, high, hit;

    // Table length clamped to the usable range, and the indices near the end.
    always_comb begin
        if (table_length < LEN_W'(LEN_MIN)) begin
            n_eff = LEN_W'(LEN_MIN);
        end else if (table_length > LEN_W'(TABLE_DEPTH)) begin
            n_eff = LEN_W'(TABLE_DEPTH);
        end else begin
            n_eff = table_length;
        end
    end

    assign idx_last  = IDX_W'(n_eff - LEN_W'(1));
    assign idx_pen   = IDX_W'(n_eff - LEN_W'(2));
    assign idx_third = IDX_W'(n_eff - LEN_W'(3));

    assign accept = in_valid && (state_reg == ST_IDLE);

    // Case tests; in ST_DECIDE the read data is t[n-2], in ST_SCAN it is t[k].
    assign above = q_reg > tl_reg;
    assign below = q_reg <= t0_reg;
    assign low   = q_reg <= t1_reg;
    assign high  = q_reg > ram_rdata;
    assign hit   = (k_reg == idx_pen) || (q_reg <= ram_rdata);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid && in_action == ACTION_QUERY) begin
                    state_next = ST_RD_LAST;
                end
            end
            ST_RD_LAST: state_next = ST_RD_ZERO;
            ST_RD_ZERO: state_next = ST_RD_ONE;
            ST_RD_ONE:  state_next = ST_RD_PEN;
            ST_RD_PEN:  state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (above || below) begin
                    state_next = ST_EMIT;
                end else if (low || high) begin
                    state_next = ST_TAIL;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL: state_next = ST_EMIT;
            ST_EMIT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake and table access per state.
    always_comb begin
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        ram_req.we    = 1'b0;
        ram_req.waddr = in_index;
        ram_req.wdata = in_angle;
        ram_req.raddr = '0;
        case (state_reg)
            ST_IDLE: begin
                in_ready   = 1'b1;
                ram_req.we = in_valid && (in_action == ACTION_WRITE);
            end
            ST_RD_LAST: ram_req.raddr = idx_last;
            ST_RD_ZERO: ram_req.raddr = '0;
            ST_RD_ONE:  ram_req.raddr = IDX_W'(1);
            ST_RD_PEN:  ram_req.raddr = idx_pen;
            ST_DECIDE: begin
                ram_req.raddr = (!low && high) ? idx_third : IDX_W'(2);
            end
            ST_SCAN:    ram_req.raddr = k_reg + IDX_W'(1);
            ST_TAIL:    ram_req.raddr = '0;
            ST_EMIT:    res_valid = 1'b1;
            default:    ram_req.raddr = '0;
        endcase
    end

    // Datapath: capture fetched angles, walk the scan window, build the result.
    always_comb begin
        q_next    = q_reg;
        tl_next   = tl_reg;
        t0_next   = t0_reg;
        t1_next   = t1_reg;
        tp_next   = tp_reg;
        wa_next   = wa_reg;
        wb_next   = wb_reg;
        wc_next   = wc_reg;
        k_next    = k_reg;
        mode_next = mode_reg;
        res_next  = res_reg;
        case (state_reg)
            ST_IDLE: begin
                // The query keeps only its low bits: one turn is the modulus.
                if (accept) begin
                    q_next = in_query[ANGLE_W-1:0];
                end
            end
            ST_RD_ZERO: tl_next = ram_rdata;
            ST_RD_ONE:  t0_next = ram_rdata;
            ST_RD_PEN:  t1_next = ram_rdata;
            ST_DECIDE: begin
                tp_next                = ram_rdata;
                res_next.wrapped_query = q_reg;
                res_next.index_a       = idx_pen;
                res_next.index_b       = idx_last;
                res_next.index_c       = '0;
                res_next.index_d       = IDX_W'(1);
                if (above) begin
                    // Query past the last entry: the first two lie one turn up.
                    res_next.angle_a = widen(ram_rdata);
                    res_next.angle_b = widen(tl_reg);
                    res_next.angle_c = plus_turn(t0_reg);
                    res_next.angle_d = plus_turn(t1_reg);
                end else begin
                    // Query at or below the first entry: the last two lie one turn down.
                    res_next.angle_a = minus_turn(ram_rdata);
                    res_next.angle_b = minus_turn(tl_reg);
                    res_next.angle_c = widen(t0_reg);
                    res_next.angle_d = widen(t1_reg);
                end
                if (low) begin
                    mode_next = MODE_LOW;
                end else if (high) begin
                    mode_next = MODE_HIGH;
                end else begin
                    mode_next = MODE_SCAN;
                end
                k_next  = IDX_W'(2);
                wa_next = t0_reg;
                wb_next = t1_reg;
            end
            ST_SCAN: begin
                if (hit) begin
                    wc_next = ram_rdata;
                end else begin
                    wa_next = wb_reg;
                    wb_next = ram_rdata;
                    k_next  = k_reg + IDX_W'(1);
                end
            end
            ST_TAIL: begin
                res_next.wrapped_query = q_reg;
                case (mode_reg)
                    MODE_LOW: begin
                        res_next.index_a = idx_last;
                        res_next.index_b = '0;
                        res_next.index_c = IDX_W'(1);
                        res_next.index_d = IDX_W'(2);
                        res_next.angle_a = minus_turn(tl_reg);
                        res_next.angle_b = widen(t0_reg);
                        res_next.angle_c = widen(t1_reg);
                        res_next.angle_d = widen(ram_rdata);
                    end
                    MODE_HIGH: begin
                        res_next.index_a = idx_third;
                        res_next.index_b = idx_pen;
                        res_next.index_c = idx_last;
                        res_next.index_d = '0;
                        res_next.angle_a = widen(ram_rdata);
                        res_next.angle_b = widen(tp_reg);
                        res_next.angle_c = widen(tl_reg);
                        res_next.angle_d = plus_turn(t0_reg);
                    end
                    default: begin
                        res_next.index_a = k_reg - IDX_W'(2);
                        res_next.index_b = k_reg - IDX_W'(1);
                        res_next.index_c = k_reg;
                        res_next.index_d = k_reg + IDX_W'(1);
                        res_next.angle_a = widen(wa_reg);
                        res_next.angle_b = widen(wb_reg);
                        res_next.angle_c = widen(wc_reg);
                        res_next.angle_d = widen(ram_rdata);
                    end
                endcase
            end
            default: begin
                k_next = k_reg;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        q_reg    <= q_next;
        tl_reg   <= tl_next;
        t0_reg   <= t0_next;
        t1_reg   <= t1_next;
        tp_reg   <= tp_next;
        wa_reg   <= wa_next;
        wb_reg   <= wb_next;
        wc_reg   <= wc_next;
        k_reg    <= k_next;
        mode_reg <= mode_next;
        res_reg  <= res_next;
    end

    assign res = res_reg;

endmodule
